FILE: hdl/addressed_fixed_frame_receiver_unit_assert.svh
// Assertion macros shared by the frame receiver modules.
`ifndef ADDRESSED_FIXED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define ADDRESSED_FIXED_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define AFFR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define AFFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/affr_pkg.sv
// Types and constants of the addressed fixed frame receiver.
`default_nettype none
package affr_pkg;

  localparam int unsigned ADDR_W        = 4;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PAYLOAD_FIRST = 3;
  localparam int unsigned PAYLOAD_BYTES = 6;
  localparam int unsigned PAYLOAD_W     = 8 * PAYLOAD_BYTES;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QUEUE_AW      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_END_BYTE   = 2'd1;
  localparam logic [1:0] REG_STATION_ID = 2'd2;

  localparam logic [7:0] START_BYTE_RST = 8'hAB;
  localparam logic [7:0] END_BYTE_RST   = 8'hCD;
  localparam logic [9:0] STATION_RST    = 10'd0;

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [9:0] station_id;
  } cfg_t;

  typedef struct packed {
    logic                 status;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

endpackage
`default_nettype wire

FILE: hdl/affr_cfg.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module affr_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [affr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [affr_pkg::DATA_W-1:0]   pwdata,
  output logic      [affr_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output affr_pkg::cfg_t                     cfg_o
);
  import affr_pkg::*;

  logic [7:0] start_q, start_d;
  logic [7:0] end_q, end_d;
  logic [9:0] station_q, station_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    start_d   = start_q;
    end_d     = end_q;
    station_d = station_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_START_BYTE: start_d   = pwdata[7:0];
        REG_END_BYTE:   end_d     = pwdata[7:0];
        REG_STATION_ID: station_d = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START_BYTE: prdata = {24'd0, start_q};
      REG_END_BYTE:   prdata = {24'd0, end_q};
      REG_STATION_ID: prdata = {22'd0, station_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= START_BYTE_RST;
      end_q     <= END_BYTE_RST;
      station_q <= STATION_RST;
    end else begin
      start_q   <= start_d;
      end_q     <= end_d;
      station_q <= station_d;
    end
  end

  assign cfg_o.start_byte = start_q;
  assign cfg_o.end_byte   = end_q;
  assign cfg_o.station_id = station_q;

endmodule
`default_nettype wire

FILE: hdl/affr_front.sv
// Front end: start byte hunt, frame collection and frame check.
`default_nettype none
`include "addressed_fixed_frame_receiver_unit_assert.svh"
module affr_front #(
  parameter int unsigned FRAME_BYTES = 10
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire affr_pkg::cfg_t cfg_i,
  input  wire logic           push_i,
  input  wire logic [7:0]     rx_byte_i,
  output logic                full_o,
  input  wire logic           q_full_i,
  output logic                enq_valid_o,
  output affr_pkg::entry_t    enq_o
);
  import affr_pkg::*;

  localparam int unsigned PW = $clog2(FRAME_BYTES);
  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BYTES - 1);

  localparam logic ST_WAIT = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic          state_q, state_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    store_q [1:FRAME_BYTES-2];
  logic          last_byte;
  logic          accept;
  logic          frame_ok;
  logic [7:0]    id_hi;
  logic [PAYLOAD_W-1:0] payload_w;

  assign last_byte = (state_q == ST_READ) && (pos_q == LAST_POS);
  // stall only on a closing byte that has no room in the queue
  assign full_o    = last_byte && q_full_i;
  assign accept    = push_i && !full_o;

  assign id_hi    = {6'd0, cfg_i.station_id[9:8]};
  assign frame_ok = (rx_byte_i == cfg_i.end_byte) && (store_q[1] == id_hi) &&
                    (store_q[2] == cfg_i.station_id[7:0]);

  // payload byte positions at or past the last frame byte read as zero
  for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_pay
    localparam int unsigned IDX = PAYLOAD_FIRST + k;
    if (IDX + 2 <= FRAME_BYTES) begin : g_byte
      assign payload_w[PAYLOAD_W-1-8*k -: 8] = store_q[IDX];
    end else begin : g_zero
      assign payload_w[PAYLOAD_W-1-8*k -: 8] = 8'd0;
    end
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    if (accept) begin
      unique case (state_q)
        ST_WAIT: begin
          if (rx_byte_i == cfg_i.start_byte) begin
            state_d = ST_READ;
            pos_d   = PW'(1);
          end
        end
        ST_READ: begin
          if (last_byte) begin
            state_d = ST_WAIT;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + PW'(1);
          end
        end
        default: begin
          state_d = ST_WAIT;
          pos_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 1; i <= FRAME_BYTES - 2; i++) begin
      if (accept && (state_q == ST_READ) && (pos_q == PW'(i))) begin
        store_q[i] <= rx_byte_i;
      end
    end
  end

  assign enq_valid_o   = accept && last_byte;
  assign enq_o.status  = frame_ok ? STATUS_GOOD : STATUS_BAD;
  assign enq_o.payload = payload_w;

  `AFFR_ASSERT_NEXT(a_front_rewait, enq_valid_o, state_q == ST_WAIT, "front did not rewait")
  `AFFR_ASSERT_ALWAYS(a_front_noovf, !(enq_valid_o && q_full_i), "word pushed into full queue")

endmodule
`default_nettype wire

FILE: hdl/affr_queue.sv
// Short queue of checked frames between front and back end.
`default_nettype none
`include "addressed_fixed_frame_receiver_unit_assert.svh"
module affr_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire affr_pkg::entry_t din_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output affr_pkg::entry_t      dout_o,
  output logic                  empty_o
);
  import affr_pkg::*;

  entry_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wptr_q, wptr_d;
  logic [QUEUE_AW-1:0]   rptr_q, rptr_d;
  logic [QUEUE_CW-1:0]   cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QUEUE_AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QUEUE_AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + QUEUE_CW'(1);
      2'b01:   cnt_d = cnt_q - QUEUE_CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= din_i;
    end
  end

  `AFFR_ASSERT_ALWAYS(a_queue_cnt, cnt_q <= QUEUE_CW'(QUEUE_DEPTH), "queue count overflow")

endmodule
`default_nettype wire

FILE: hdl/affr_back.sv
// Back end: frame counters and the result output register.
`default_nettype none
`include "addressed_fixed_frame_receiver_unit_assert.svh"
module affr_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            q_empty_i,
  input  wire affr_pkg::entry_t                q_data_i,
  output logic                                 q_pop_o,
  input  wire logic                            pop,
  output logic                                 empty,
  output logic                                 frame_status_o,
  output logic      [affr_pkg::PAYLOAD_W-1:0]  payload_o,
  output logic      [15:0]                     good_frames_o,
  output logic      [15:0]                     bad_frames_o
);
  import affr_pkg::*;

  logic                 out_valid_q, out_valid_d;
  logic [15:0]          good_q, good_d;
  logic [15:0]          bad_q, bad_d;
  logic                 status_q;
  logic [PAYLOAD_W-1:0] payload_q;
  logic                 take;
  logic                 load;
  logic                 load_good;
  logic [15:0]          good_inc;

  assign take    = pop && out_valid_q;
  // refill the output register when it is free or being drained
  assign load    = !q_empty_i && (!out_valid_q || take);
  assign q_pop_o = load;

  assign load_good = load && (q_data_i.status == STATUS_GOOD);
  assign good_inc  = good_q + 16'd1;

  always_comb begin
    good_d      = good_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (q_data_i.status == STATUS_GOOD) begin
        good_d = good_inc;
      end else begin
        bad_d = bad_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      good_q      <= '0;
      bad_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q  <= q_data_i.status;
      payload_q <= q_data_i.payload;
    end
  end

  assign empty          = !out_valid_q;
  assign frame_status_o = status_q;
  assign payload_o      = payload_q;
  assign good_frames_o  = good_q;
  assign bad_frames_o   = bad_q;

  `AFFR_ASSERT_NEXT(a_back_good, load_good, good_q == $past(good_inc), "good count step wrong")
  `AFFR_ASSERT_NEXT(a_back_hold, !load, $stable(good_q) && $stable(bad_q), "counter moved idle")
  `AFFR_ASSERT_NEXT(a_back_drain, take && !load, !out_valid_q, "result shown twice")

endmodule
`default_nettype wire

FILE: hdl/addressed_fixed_frame_receiver_unit.sv
// Top level of the addressed fixed frame receiver.
//
//   channel   | side   | handshake                   | word
//   ----------+--------+-----------------------------+------------------------------------
//   bytes     | input  | push / full                 | rx_byte_i
//   results   | output | empty / pop                 | frame_status_o, payload_o, counts
//   registers | input  | psel, penable, pwrite/pready | start byte, end byte, station id
//
// One byte is taken every cycle while full is low; a frame's result passes through the
// queue register, then the output register, before it reaches the output.
// full rises only on the closing byte of a frame while the two-entry frame queue is full.
// Reset clears the hunt state, position, queue pointers and count, output valid flag and both counters at once.
// Bytes that do not close a frame are never stalled by a waiting result.
`default_nettype none
module addressed_fixed_frame_receiver_unit #(
  parameter int unsigned FRAME_BYTES = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [affr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [affr_pkg::DATA_W-1:0]   pwdata,
  output logic      [affr_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               frame_status_o,
  output logic      [affr_pkg::PAYLOAD_W-1:0] payload_o,
  output logic      [15:0]                   good_frames_o,
  output logic      [15:0]                   bad_frames_o
);
  import affr_pkg::*;

  cfg_t   cfg;
  entry_t enq_word;
  entry_t deq_word;
  logic   enq_valid;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  affr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  affr_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push_i      (push),
    .rx_byte_i   (rx_byte_i),
    .full_o      (full),
    .q_full_i    (q_full),
    .enq_valid_o (enq_valid),
    .enq_o       (enq_word)
  );

  affr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq_valid),
    .din_i   (enq_word),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (deq_word),
    .empty_o (q_empty)
  );

  affr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (deq_word),
    .q_pop_o        (q_pop),
    .pop            (pop),
    .empty          (empty),
    .frame_status_o (frame_status_o),
    .payload_o      (payload_o),
    .good_frames_o  (good_frames_o),
    .bad_frames_o   (bad_frames_o)
  );

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Testbench for the addressed fixed frame receiver: frame prediction and result checks.
`default_nettype none
module tb_top;
  import affr_pkg::*;

  localparam int unsigned FRAME_LEN   = 10;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [1:0]  REG_SPARE   = 2'd3;

  typedef struct {
    logic                 status;
    logic [PAYLOAD_W-1:0] payload;
    logic [15:0]          good;
    logic [15:0]          bad;
  } frame_word_t;

  // Tracks the hunt and collect state of the receiver and queues the frame words it owes.
  class frame_scoreboard;
    logic [7:0]   start_b;
    logic [7:0]   end_b;
    logic [9:0]   station;
    bit           reading;
    int unsigned  pos;
    logic [7:0]   store [FRAME_LEN];
    logic [15:0]  good_cnt;
    logic [15:0]  bad_cnt;
    frame_word_t  expected_frames [$];
    int           errors;

    function new();
      start_b  = START_BYTE_RST;
      end_b    = END_BYTE_RST;
      station  = STATION_RST;
      reading  = 1'b0;
      pos      = 0;
      good_cnt = '0;
      bad_cnt  = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_START_BYTE: start_b = val[7:0];
        REG_END_BYTE:   end_b   = val[7:0];
        REG_STATION_ID: station = val[9:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      frame_word_t w;
      bit          ok;
      logic [7:0]  pb;
      int unsigned k;
      if (!reading) begin
        // drop everything but the start byte while hunting
        if (b == start_b) begin
          store[0] = b;
          pos      = 1;
          reading  = 1'b1;
        end
        return;
      end
      store[pos] = b;
      if (pos != FRAME_LEN - 1) begin
        pos++;
        return;
      end
      ok = (b == end_b) && (store[1] == {6'b0, station[9:8]}) && (store[2] == station[7:0]);
      if (ok) good_cnt++;
      else    bad_cnt++;
      w.status  = ok ? STATUS_GOOD : STATUS_BAD;
      w.payload = '0;
      for (k = 0; k < PAYLOAD_BYTES; k++) begin
        // positions at or past the closing byte read as zero
        pb = (PAYLOAD_FIRST + k < FRAME_LEN - 1) ? store[PAYLOAD_FIRST + k] : 8'h00;
        w.payload = {w.payload[PAYLOAD_W-9:0], pb};
      end
      w.good = good_cnt;
      w.bad  = bad_cnt;
      expected_frames.push_back(w);
      reading = 1'b0;
      pos     = 0;
    endfunction

    function void check_frame(logic status, logic [PAYLOAD_W-1:0] payload,
                              logic [15:0] good, logic [15:0] bad);
      frame_word_t w;
      if (expected_frames.size() == 0) begin
        $error("result word with no frame pending");
        errors++;
        return;
      end
      w = expected_frames.pop_front();
      if (status !== w.status) begin
        $error("frame_status: expected %0d, actual %0d", w.status, status);
        errors++;
      end
      if (payload !== w.payload) begin
        $error("payload: expected %h, actual %h", w.payload, payload);
        errors++;
      end
      if (good !== w.good) begin
        $error("good_frames: expected %0d, actual %0d", w.good, good);
        errors++;
      end
      if (bad !== w.bad) begin
        $error("bad_frames: expected %0d, actual %0d", w.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 push;
  logic                 full;
  logic [7:0]           rx_byte;
  logic                 empty;
  logic                 pop;
  logic                 frame_status;
  logic [PAYLOAD_W-1:0] payload;
  logic [15:0]          good_frames;
  logic [15:0]          bad_frames;

  frame_scoreboard sb;
  int unsigned     in_idle_pct;
  int unsigned     out_idle_pct;
  int unsigned     bytes_sent;
  int unsigned     cycles;

  addressed_fixed_frame_receiver_unit #(
    .FRAME_BYTES(FRAME_LEN)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte),
    .empty          (empty),
    .pop            (pop),
    .frame_status_o (frame_status),
    .payload_o      (payload),
    .good_frames_o  (good_frames),
    .bad_frames_o   (bad_frames)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result side: check each word taken, stall at random.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        sb.check_frame(frame_status, payload, good_frames, bad_frames);
      end
      pop <= rst_ni && ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (full);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic send_frame(input bit id_ok, input bit end_ok, input logic [47:0] data);
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  last;
    int unsigned k;
    hi = {6'b0, sb.station[9:8]};
    lo = sb.station[7:0];
    if (!id_ok) begin
      if ($urandom_range(0, 1) != 0) hi = hi ^ 8'($urandom_range(1, 255));
      else                            lo = lo ^ 8'($urandom_range(1, 255));
    end
    last = end_ok ? sb.end_b : (sb.end_b ^ 8'($urandom_range(1, 255)));
    send_byte(sb.start_b);
    send_byte(hi);
    send_byte(lo);
    for (k = 3; k < FRAME_LEN - 1; k++) begin
      send_byte(data[47 - 8 * ((k - 3) % 6) -: 8]);
    end
    send_byte(last);
  endtask

  // Close any open frame, then wait out every owed word and the output pipeline.
  task automatic drain();
    while (sb.reading) send_byte(8'($urandom));
    push <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    int unsigned target;
    int unsigned r;
    logic [47:0] data;
    sb           = new();
    in_idle_pct  = 13;
    out_idle_pct = 13;
    bytes_sent   = 0;
    rst_ni  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    push    <= 1'b0;
    rx_byte <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ignored while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    // accepted frame carrying the start byte as data
    send_frame(1'b1, 1'b1, 48'hFFAB_FFFF_FFAB);
    // wrong end byte, payload still reported
    send_frame(1'b1, 1'b0, 48'h0000_0000_0000);

    target = bytes_sent;
    for (phase = 0; phase < 6; phase++) begin
      drain();
      in_idle_pct  = 13;
      out_idle_pct = 13;
      case (phase)
        1: begin
          cfg_write(REG_START_BYTE, 32'h0000_0000);
          cfg_write(REG_END_BYTE,   32'h0000_00FF);
          cfg_write(REG_STATION_ID, 32'h0000_03FF);
        end
        2: begin
          cfg_write(REG_START_BYTE, 32'h0000_00FF);
          cfg_write(REG_END_BYTE,   32'h0000_0000);
          cfg_write(REG_STATION_ID, 32'h0000_0000);
          cfg_write(REG_SPARE,      $urandom);
        end
        3, 4: begin
          cfg_write(REG_START_BYTE, $urandom);
          cfg_write(REG_END_BYTE,   $urandom);
          cfg_write(REG_STATION_ID, $urandom);
          // hold both sides busy for the whole phase
          if (phase == 3) begin
            in_idle_pct  = 0;
            out_idle_pct = 0;
          end
        end
        5: begin
          cfg_write(REG_SPARE,      $urandom);
          cfg_write(REG_START_BYTE, 32'(START_BYTE_RST));
          cfg_write(REG_END_BYTE,   32'(END_BYTE_RST));
          cfg_write(REG_STATION_ID, $urandom_range(0, 1023));
        end
        default: ;
      endcase
      target += 115;
      while (bytes_sent < target) begin
        r    = $urandom_range(0, 99);
        data = {$urandom, $urandom};
        if (r < 70) begin
          send_frame($urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0, data);
        end else if (r < 85) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else begin
          // cut a frame short; the next bytes land inside it
          send_byte(sb.start_b);
          repeat ($urandom_range(1, FRAME_LEN - 2)) send_byte(8'($urandom));
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.expected_frames.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
